// ----- src/wpa_pkg.sv -----
`default_nettype none

package wpa_pkg;

   // Field widths fixed by the item formats.
   localparam int ENTRY_IDX_W = 4;
   localparam int SNAP_TIME_W = 63;
   localparam int SNAP_COUNT_W = 31;
   localparam int SUM_TIME_W = 64;
   localparam int SUM_COUNT_W = 32;
   localparam int TALLY_W = 32;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } wpa_state_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic update;
   } wpa_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } wpa_status_type;

   typedef struct packed {
      logic [SNAP_TIME_W-1:0]  hist_time;
      logic [SNAP_COUNT_W-1:0] hist_count;
   } wpa_hist_type;

endpackage

`default_nettype wire

// ----- src/windowed_profile_accumulator_unit.sv -----
`default_nettype none

// Channel   Direction  Handshake            Beat contents
// req_      in         req_valid/req_ready  entry index, active, time, count, end of frame
// rsp_      out        rsp_valid/rsp_ready  window, peak and total sums, frames, window done
// csr_      in         csr_valid/csr_ready  enable bit (always ready)
//
// Each item is first accepted, with its history slot read from the single-port history
// RAM, and then its entry is updated and the result register loaded.
// After reset the history RAM is cleared one row a cycle, all NUM_ENTRIES * WINDOW_FRAMES
// rows (1920 by default), and req_ready stays low until that pass ends.
// A result waits in its register until taken; the next item is accepted meanwhile,
// but its update holds until the result register is free.

module windowed_profile_accumulator_unit #(
   parameter int WINDOW_FRAMES = 120,
   parameter int NUM_ENTRIES = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire                                  csr_enable,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [wpa_pkg::ENTRY_IDX_W-1:0]      req_entry_index,
   input  wire                                  req_entry_active,
   input  wire  [wpa_pkg::SNAP_TIME_W-1:0]      req_snap_time,
   input  wire  [wpa_pkg::SNAP_COUNT_W-1:0]     req_snap_count,
   input  wire                                  req_end_of_frame,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [wpa_pkg::SUM_TIME_W-1:0]       rsp_window_time,
   output logic [wpa_pkg::SUM_COUNT_W-1:0]      rsp_window_count,
   output logic [wpa_pkg::SNAP_TIME_W-1:0]      rsp_peak_time,
   output logic [wpa_pkg::SNAP_COUNT_W-1:0]     rsp_peak_count,
   output logic [wpa_pkg::SUM_TIME_W-1:0]       rsp_total_time,
   output logic [wpa_pkg::SUM_COUNT_W-1:0]      rsp_total_count,
   output logic [wpa_pkg::TALLY_W-1:0]          rsp_frames_recorded,
   output logic                                 rsp_window_done
);

   wpa_pkg::wpa_cmd_type    cmd;
   wpa_pkg::wpa_status_type status;

   assign csr_ready = 1'b1;

   wpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wpa_datapath #(
      .WINDOW_FRAMES (WINDOW_FRAMES),
      .NUM_ENTRIES   (NUM_ENTRIES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_we              (csr_valid),
      .csr_enable          (csr_enable),
      .req_entry_index     (req_entry_index),
      .req_entry_active    (req_entry_active),
      .req_snap_time       (req_snap_time),
      .req_snap_count      (req_snap_count),
      .req_end_of_frame    (req_end_of_frame),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_window_time     (rsp_window_time),
      .rsp_window_count    (rsp_window_count),
      .rsp_peak_time       (rsp_peak_time),
      .rsp_peak_count      (rsp_peak_count),
      .rsp_total_time      (rsp_total_time),
      .rsp_total_count     (rsp_total_count),
      .rsp_frames_recorded (rsp_frames_recorded),
      .rsp_window_done     (rsp_window_done)
   );

endmodule

`default_nettype wire

// ----- src/wpa_ctrl.sv -----
`default_nettype none

module wpa_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wpa_pkg::wpa_status_type status,
   output wpa_pkg::wpa_cmd_type    cmd
);

   wpa_pkg::wpa_state_type state_ff;
   wpa_pkg::wpa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpa_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wpa_pkg::ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = wpa_pkg::ST_IDLE;
            end
         end
         wpa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = wpa_pkg::ST_UPDATE;
            end
         end
         wpa_pkg::ST_UPDATE: begin
            // The update waits while the previous result has not been taken.
            if (status.out_free) begin
               state_in = wpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wpa_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         wpa_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         wpa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_valid;
         end
         wpa_pkg::ST_UPDATE: begin
            cmd.update = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- src/wpa_datapath.sv -----
`default_nettype none

module wpa_datapath #(
   parameter int WINDOW_FRAMES = 120,
   parameter int NUM_ENTRIES = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wpa_pkg::wpa_cmd_type                 cmd,
   output wpa_pkg::wpa_status_type              status,
   input  wire                                  csr_we,
   input  wire                                  csr_enable,
   input  wire  [wpa_pkg::ENTRY_IDX_W-1:0]      req_entry_index,
   input  wire                                  req_entry_active,
   input  wire  [wpa_pkg::SNAP_TIME_W-1:0]      req_snap_time,
   input  wire  [wpa_pkg::SNAP_COUNT_W-1:0]     req_snap_count,
   input  wire                                  req_end_of_frame,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [wpa_pkg::SUM_TIME_W-1:0]       rsp_window_time,
   output logic [wpa_pkg::SUM_COUNT_W-1:0]      rsp_window_count,
   output logic [wpa_pkg::SNAP_TIME_W-1:0]      rsp_peak_time,
   output logic [wpa_pkg::SNAP_COUNT_W-1:0]     rsp_peak_count,
   output logic [wpa_pkg::SUM_TIME_W-1:0]       rsp_total_time,
   output logic [wpa_pkg::SUM_COUNT_W-1:0]      rsp_total_count,
   output logic [wpa_pkg::TALLY_W-1:0]          rsp_frames_recorded,
   output logic                                 rsp_window_done
);

   localparam int DEPTH = NUM_ENTRIES * WINDOW_FRAMES;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int FRAME_W = $clog2(WINDOW_FRAMES);
   localparam int ENTRY_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int EXT_W = 9;

   localparam int TW = wpa_pkg::SNAP_TIME_W;
   localparam int CW = wpa_pkg::SNAP_COUNT_W;
   localparam int STW = wpa_pkg::SUM_TIME_W;
   localparam int SCW = wpa_pkg::SUM_COUNT_W;
   localparam int FTW = wpa_pkg::TALLY_W;

   // History store, one row per (entry, frame) slot.
   wpa_pkg::wpa_hist_type hist_mem [DEPTH];
   wpa_pkg::wpa_hist_type hist_rd_ff;

   logic               enable_ff, enable_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [SLOT_W-1:0]  clear_addr_ff, clear_addr_in;

   // Captured item.
   logic [ENTRY_W-1:0] item_entry_ff, item_entry_in;
   logic               item_ok_ff, item_ok_in;
   logic               item_active_ff;
   logic [TW-1:0]      item_time_ff;
   logic [CW-1:0]      item_count_ff;
   logic               item_eof_ff;
   logic [SLOT_W-1:0]  item_slot_ff, item_slot_in;

   // Per-entry statistics; an entry not yet written reads as zero.
   logic [NUM_ENTRIES-1:0] stat_vld_ff;
   logic [STW-1:0] roll_time_ff  [NUM_ENTRIES];
   logic [SCW-1:0] roll_count_ff [NUM_ENTRIES];
   logic [TW-1:0]  max_time_ff   [NUM_ENTRIES];
   logic [CW-1:0]  max_count_ff  [NUM_ENTRIES];
   logic [STW-1:0] grand_time_ff [NUM_ENTRIES];
   logic [SCW-1:0] grand_count_ff[NUM_ENTRIES];
   logic [FTW-1:0] tally_ff      [NUM_ENTRIES];

   logic [EXT_W-1:0] entry_ext;

   logic [STW-1:0] cur_roll_time, new_roll_time, res_roll_time;
   logic [SCW-1:0] cur_roll_count, new_roll_count, res_roll_count;
   logic [TW-1:0]  cur_max_time, new_max_time, res_max_time;
   logic [CW-1:0]  cur_max_count, new_max_count, res_max_count;
   logic [STW-1:0] cur_grand_time, new_grand_time, res_grand_time;
   logic [SCW-1:0] cur_grand_count, new_grand_count, res_grand_count;
   logic [FTW-1:0] cur_tally, new_tally, res_tally;
   logic           do_upd;
   logic           frame_last;

   logic                  mem_we;
   logic [SLOT_W-1:0]     mem_waddr;
   wpa_pkg::wpa_hist_type mem_wdata;

   logic rsp_valid_ff, rsp_valid_in;
   logic [STW-1:0] rsp_window_time_ff;
   logic [SCW-1:0] rsp_window_count_ff;
   logic [TW-1:0]  rsp_peak_time_ff;
   logic [CW-1:0]  rsp_peak_count_ff;
   logic [STW-1:0] rsp_total_time_ff;
   logic [SCW-1:0] rsp_total_count_ff;
   logic [FTW-1:0] rsp_frames_ff;
   logic           rsp_done_ff;

   // Slot address of the incoming item, formed as it is accepted.
   always_comb begin
      entry_ext = {{(EXT_W-wpa_pkg::ENTRY_IDX_W){1'b0}}, req_entry_index};
      item_ok_in = (entry_ext < EXT_W'(NUM_ENTRIES));
      item_entry_in = item_ok_in ? entry_ext[ENTRY_W-1:0] : '0;
      item_slot_in = SLOT_W'(item_entry_in) * SLOT_W'(WINDOW_FRAMES) + SLOT_W'(frame_ff);
   end

   always_comb begin
      cur_roll_time   = stat_vld_ff[item_entry_ff] ? roll_time_ff[item_entry_ff] : '0;
      cur_roll_count  = stat_vld_ff[item_entry_ff] ? roll_count_ff[item_entry_ff] : '0;
      cur_max_time    = stat_vld_ff[item_entry_ff] ? max_time_ff[item_entry_ff] : '0;
      cur_max_count   = stat_vld_ff[item_entry_ff] ? max_count_ff[item_entry_ff] : '0;
      cur_grand_time  = stat_vld_ff[item_entry_ff] ? grand_time_ff[item_entry_ff] : '0;
      cur_grand_count = stat_vld_ff[item_entry_ff] ? grand_count_ff[item_entry_ff] : '0;
      cur_tally       = stat_vld_ff[item_entry_ff] ? tally_ff[item_entry_ff] : '0;

      do_upd = item_ok_ff & enable_ff & item_active_ff;

      // The old slot value leaves the window and the new snapshot enters it.
      new_roll_time = cur_roll_time - {1'b0, hist_rd_ff.hist_time} + {1'b0, item_time_ff};
      new_roll_count = cur_roll_count - {1'b0, hist_rd_ff.hist_count}
                       + {1'b0, item_count_ff};
      new_max_time = (item_time_ff > cur_max_time) ? item_time_ff : cur_max_time;
      new_max_count = (item_count_ff > cur_max_count) ? item_count_ff : cur_max_count;
      new_grand_time = cur_grand_time + {1'b0, item_time_ff};
      new_grand_count = cur_grand_count + {1'b0, item_count_ff};
      new_tally = cur_tally + FTW'(1);

      if (!item_ok_ff) begin
         res_roll_time = '0;
         res_roll_count = '0;
         res_max_time = '0;
         res_max_count = '0;
         res_grand_time = '0;
         res_grand_count = '0;
         res_tally = '0;
      end else if (do_upd) begin
         res_roll_time = new_roll_time;
         res_roll_count = new_roll_count;
         res_max_time = new_max_time;
         res_max_count = new_max_count;
         res_grand_time = new_grand_time;
         res_grand_count = new_grand_count;
         res_tally = new_tally;
      end else begin
         res_roll_time = cur_roll_time;
         res_roll_count = cur_roll_count;
         res_max_time = cur_max_time;
         res_max_count = cur_max_count;
         res_grand_time = cur_grand_time;
         res_grand_count = cur_grand_count;
         res_tally = cur_tally;
      end

      frame_last = (frame_ff == FRAME_W'(WINDOW_FRAMES - 1));
      frame_in = frame_ff;
      if (cmd.update && item_eof_ff) begin
         frame_in = frame_last ? '0 : frame_ff + FRAME_W'(1);
      end

      enable_in = csr_we ? csr_enable : enable_ff;
      clear_addr_in = cmd.clear_step ? clear_addr_ff + SLOT_W'(1) : clear_addr_ff;

      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      mem_we = cmd.clear_step | (cmd.update & do_upd);
      mem_waddr = cmd.clear_step ? clear_addr_ff : item_slot_ff;
      mem_wdata.hist_time = cmd.clear_step ? '0 : item_time_ff;
      mem_wdata.hist_count = cmd.clear_step ? '0 : item_count_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.capture) begin
         hist_rd_ff <= hist_mem[item_slot_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         frame_ff <= '0;
         clear_addr_ff <= '0;
         stat_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
         frame_ff <= frame_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.update && do_upd) begin
            stat_vld_ff[item_entry_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_entry_ff <= item_entry_in;
         item_ok_ff <= item_ok_in;
         item_active_ff <= req_entry_active;
         item_time_ff <= req_snap_time;
         item_count_ff <= req_snap_count;
         item_eof_ff <= req_end_of_frame;
         item_slot_ff <= item_slot_in;
      end
      if (cmd.update && do_upd) begin
         roll_time_ff[item_entry_ff] <= new_roll_time;
         roll_count_ff[item_entry_ff] <= new_roll_count;
         max_time_ff[item_entry_ff] <= new_max_time;
         max_count_ff[item_entry_ff] <= new_max_count;
         grand_time_ff[item_entry_ff] <= new_grand_time;
         grand_count_ff[item_entry_ff] <= new_grand_count;
         tally_ff[item_entry_ff] <= new_tally;
      end
      if (cmd.update) begin
         rsp_window_time_ff <= res_roll_time;
         rsp_window_count_ff <= res_roll_count;
         rsp_peak_time_ff <= res_max_time;
         rsp_peak_count_ff <= res_max_count;
         rsp_total_time_ff <= res_grand_time;
         rsp_total_count_ff <= res_grand_count;
         rsp_frames_ff <= res_tally;
         rsp_done_ff <= item_eof_ff & frame_last;
      end
   end

   always_comb begin
      status.clear_last = (clear_addr_ff == SLOT_W'(DEPTH - 1));
      status.out_free = ~rsp_valid_ff | rsp_ready;
      rsp_valid = rsp_valid_ff;
      rsp_window_time = rsp_window_time_ff;
      rsp_window_count = rsp_window_count_ff;
      rsp_peak_time = rsp_peak_time_ff;
      rsp_peak_count = rsp_peak_count_ff;
      rsp_total_time = rsp_total_time_ff;
      rsp_total_count = rsp_total_count_ff;
      rsp_frames_recorded = rsp_frames_ff;
      rsp_window_done = rsp_done_ff;
   end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int WINDOW_FRAMES = 120;
   localparam int NUM_ENTRIES   = 16;
   localparam logic [wpa_pkg::SNAP_TIME_W-1:0]  TIME_MAX  = '1;
   localparam logic [wpa_pkg::SNAP_COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [wpa_pkg::ENTRY_IDX_W-1:0]  entry;
      logic                             active;
      logic [wpa_pkg::SNAP_TIME_W-1:0]  snap_time;
      logic [wpa_pkg::SNAP_COUNT_W-1:0] snap_count;
      logic                             frame_end;
   } snapshot_type;

   typedef struct packed {
      logic [wpa_pkg::SUM_TIME_W-1:0]   window_time;
      logic [wpa_pkg::SUM_COUNT_W-1:0]  window_count;
      logic [wpa_pkg::SNAP_TIME_W-1:0]  peak_time;
      logic [wpa_pkg::SNAP_COUNT_W-1:0] peak_count;
      logic [wpa_pkg::SUM_TIME_W-1:0]   total_time;
      logic [wpa_pkg::SUM_COUNT_W-1:0]  total_count;
      logic [wpa_pkg::TALLY_W-1:0]      frames_recorded;
      logic                             window_done;
   } profile_stats_type;

   logic clock;
   logic reset     = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_enable = 1'b0;
   logic csr_ready;
   logic req_valid = 1'b0;
   logic req_ready;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   snapshot_type req_beat = '0;

   logic [wpa_pkg::SUM_TIME_W-1:0]   rsp_window_time;
   logic [wpa_pkg::SUM_COUNT_W-1:0]  rsp_window_count;
   logic [wpa_pkg::SNAP_TIME_W-1:0]  rsp_peak_time;
   logic [wpa_pkg::SNAP_COUNT_W-1:0] rsp_peak_count;
   logic [wpa_pkg::SUM_TIME_W-1:0]   rsp_total_time;
   logic [wpa_pkg::SUM_COUNT_W-1:0]  rsp_total_count;
   logic [wpa_pkg::TALLY_W-1:0]      rsp_frames_recorded;
   logic                             rsp_window_done;

   // Predicted state of the block.
   logic [wpa_pkg::SNAP_TIME_W-1:0]  slot_time  [NUM_ENTRIES][WINDOW_FRAMES];
   logic [wpa_pkg::SNAP_COUNT_W-1:0] slot_count [NUM_ENTRIES][WINDOW_FRAMES];
   logic [wpa_pkg::SUM_TIME_W-1:0]   win_time   [NUM_ENTRIES];
   logic [wpa_pkg::SUM_COUNT_W-1:0]  win_count  [NUM_ENTRIES];
   logic [wpa_pkg::SNAP_TIME_W-1:0]  top_time   [NUM_ENTRIES];
   logic [wpa_pkg::SNAP_COUNT_W-1:0] top_count  [NUM_ENTRIES];
   logic [wpa_pkg::SUM_TIME_W-1:0]   sum_time   [NUM_ENTRIES];
   logic [wpa_pkg::SUM_COUNT_W-1:0]  sum_count  [NUM_ENTRIES];
   logic [wpa_pkg::TALLY_W-1:0]      tally      [NUM_ENTRIES];
   int   frame_pos = 0;
   logic updates_on = 1'b1;

   snapshot_type      snapshot_q[$];
   profile_stats_type stats_due_q[$];

   int   snapshots_taken = 0;
   int   stats_seen = 0;
   int   csr_beats = 0;
   int   mismatches = 0;
   int   windows_closed = 0;
   int   skipped_updates = 0;
   int   slots_reused = 0;
   logic req_fire = 1'b0;
   logic rsp_hold = 1'b0;
   logic calm = 1'b0;
   int   send_gap = 0;
   int   take_gap = 0;
   int   send_idle_pct [16];
   int   take_idle_pct [16];

   windowed_profile_accumulator_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_enable          (csr_enable),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_entry_index     (req_beat.entry),
      .req_entry_active    (req_beat.active),
      .req_snap_time       (req_beat.snap_time),
      .req_snap_count      (req_beat.snap_count),
      .req_end_of_frame    (req_beat.frame_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_window_time     (rsp_window_time),
      .rsp_window_count    (rsp_window_count),
      .rsp_peak_time       (rsp_peak_time),
      .rsp_peak_count      (rsp_peak_count),
      .rsp_total_time      (rsp_total_time),
      .rsp_total_count     (rsp_total_count),
      .rsp_frames_recorded (rsp_frames_recorded),
      .rsp_window_done     (rsp_window_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Applies one snapshot to the predicted state and returns the statistics it yields.
   function automatic profile_stats_type advance_profile(input snapshot_type s);
      profile_stats_type r;
      int e;
      e = int'(s.entry);
      if (updates_on && s.active) begin
         if (slot_time[e][frame_pos] != '0 || slot_count[e][frame_pos] != '0)
            slots_reused++;
         win_time[e] = win_time[e] - {1'b0, slot_time[e][frame_pos]} + {1'b0, s.snap_time};
         win_count[e] = win_count[e] - {1'b0, slot_count[e][frame_pos]}
                        + {1'b0, s.snap_count};
         slot_time[e][frame_pos] = s.snap_time;
         slot_count[e][frame_pos] = s.snap_count;
         if (s.snap_time > top_time[e])
            top_time[e] = s.snap_time;
         if (s.snap_count > top_count[e])
            top_count[e] = s.snap_count;
         sum_time[e] = sum_time[e] + {1'b0, s.snap_time};
         sum_count[e] = sum_count[e] + {1'b0, s.snap_count};
         tally[e] = tally[e] + 1;
      end else if (!updates_on) begin
         skipped_updates++;
      end
      r.window_done = 1'b0;
      if (s.frame_end) begin
         if (frame_pos == WINDOW_FRAMES - 1) begin
            frame_pos = 0;
            r.window_done = 1'b1;
            windows_closed++;
         end else begin
            frame_pos++;
         end
      end
      r.window_time = win_time[e];
      r.window_count = win_count[e];
      r.peak_time = top_time[e];
      r.peak_count = top_count[e];
      r.total_time = sum_time[e];
      r.total_count = sum_count[e];
      r.frames_recorded = tally[e];
      return r;
   endfunction

   function automatic logic [wpa_pkg::SNAP_TIME_W-1:0] pick_time();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: return TIME_MAX;
         1: return '0;
         2: return 63'($urandom_range(0, 255));
         3: return r[62:0] >> $urandom_range(0, 62);
         default: return r[62:0];
      endcase
   endfunction

   function automatic logic [wpa_pkg::SNAP_COUNT_W-1:0] pick_count();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: return COUNT_MAX;
         1: return '0;
         2: return 31'($urandom_range(0, 255));
         3: return r[30:0] >> $urandom_range(0, 30);
         default: return r[30:0];
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t ns ERROR %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                   stats_seen, name, got, want));
   endtask

   task automatic push_snapshot(input int entry, input logic active,
                                input logic [wpa_pkg::SNAP_TIME_W-1:0] t,
                                input logic [wpa_pkg::SNAP_COUNT_W-1:0] c,
                                input logic frame_end);
      snapshot_type s;
      s.entry = entry[wpa_pkg::ENTRY_IDX_W-1:0];
      s.active = active;
      s.snap_time = t;
      s.snap_count = c;
      s.frame_end = frame_end;
      snapshot_q.push_back(s);
   endtask

   // Frames of one to four snapshots, mostly from a few busy entries so that
   // history slots come round again a window later; a few frame ends are flipped.
   task automatic queue_frames(input int n);
      int left;
      int len;
      int idx;
      snapshot_type s;
      left = n;
      while (left > 0) begin
         len = $urandom_range(1, 4);
         if (len > left)
            len = left;
         for (int k = 0; k < len; k++) begin
            idx = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(0, 15);
            s.entry = idx[wpa_pkg::ENTRY_IDX_W-1:0];
            s.active = ($urandom_range(0, 9) != 0);
            s.snap_time = pick_time();
            s.snap_count = pick_count();
            s.frame_end = (k == len - 1);
            if ($urandom_range(0, 19) == 0)
               s.frame_end = ~s.frame_end;
            snapshot_q.push_back(s);
         end
         left -= len;
      end
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (snapshot_q.size() != 0 || req_valid || stats_due_q.size() != 0);
   endtask

   task automatic write_enable(input logic value);
      int start;
      start = csr_beats;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_enable <= value;
      do
         @(negedge clock);
      while (csr_beats == start);
      csr_valid <= 1'b0;
   endtask

   // Handshake bookkeeping and prediction at the rising edge.
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         stats_due_q.push_back(advance_profile(req_beat));
         snapshots_taken++;
      end
      if (!reset && csr_valid && csr_ready) begin
         updates_on = csr_enable;
         csr_beats++;
      end
   end

   // Request driver.
   always @(negedge clock) begin
      logic         next_valid;
      snapshot_type next_beat;
      next_valid = req_valid;
      next_beat = req_beat;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_fire) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (snapshot_q.size() != 0) begin
            if (!calm && $urandom_range(0, 99) < send_idle_pct[(snapshots_taken / 100) % 16]) begin
               send_gap = $urandom_range(0, 14);
            end else begin
               next_beat = snapshot_q.pop_front();
               next_valid = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
      req_beat <= next_beat;
   end

   // Response ready, with random stalls and the long hold.
   always @(negedge clock) begin
      if (reset || rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (take_gap > 0) begin
         take_gap--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < take_idle_pct[(stats_seen / 100) % 16]) begin
         take_gap = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      profile_stats_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         stats_seen++;
         if (stats_due_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      stats_seen));
         end else begin
            want = stats_due_q.pop_front();
            check_field("window_time", rsp_window_time, want.window_time);
            check_field("window_count", 64'(rsp_window_count), 64'(want.window_count));
            check_field("peak_time", 64'(rsp_peak_time), 64'(want.peak_time));
            check_field("peak_count", 64'(rsp_peak_count), 64'(want.peak_count));
            check_field("total_time", rsp_total_time, want.total_time);
            check_field("total_count", 64'(rsp_total_count), 64'(want.total_count));
            check_field("frames_recorded", 64'(rsp_frames_recorded),
                        64'(want.frames_recorded));
            check_field("window_done", 64'(rsp_window_done), 64'(want.window_done));
         end
      end
   end

   // The receiver stops for a long stretch so that the block backs up into its input.
   initial begin
      wait (snapshots_taken >= 400);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      #4000000;
      $display("windowed_profile_accumulator_unit: mismatch");
      $finish;
   end

   initial begin
      for (int e = 0; e < NUM_ENTRIES; e++) begin
         for (int f = 0; f < WINDOW_FRAMES; f++) begin
            slot_time[e][f] = '0;
            slot_count[e][f] = '0;
         end
         win_time[e] = '0;
         win_count[e] = '0;
         top_time[e] = '0;
         top_count[e] = '0;
         sum_time[e] = '0;
         sum_count[e] = '0;
         tally[e] = '0;
      end
      for (int i = 0; i < 16; i++) begin
         case ($urandom_range(0, 4))
            0, 1: send_idle_pct[i] = 0;
            2: send_idle_pct[i] = 10;
            3: send_idle_pct[i] = 30;
            default: send_idle_pct[i] = 60;
         endcase
         case ($urandom_range(0, 4))
            0, 1: take_idle_pct[i] = 0;
            2: take_idle_pct[i] = 10;
            3: take_idle_pct[i] = 30;
            default: take_idle_pct[i] = 60;
         endcase
      end

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Enable as left by reset: sums that wrap, maxima held on equal or smaller
      // values, inactive entries, a slot written twice within one frame.
      push_snapshot(0, 1'b1, TIME_MAX, COUNT_MAX, 1'b0);
      push_snapshot(15, 1'b1, '0, '0, 1'b1);
      push_snapshot(0, 1'b1, TIME_MAX, COUNT_MAX, 1'b1);
      push_snapshot(0, 1'b1, TIME_MAX, COUNT_MAX, 1'b0);
      push_snapshot(0, 1'b1, 63'd1, 31'd1, 1'b0);
      push_snapshot(1, 1'b0, 63'({32{2'b01}}), 31'({16{2'b01}}), 1'b0);
      push_snapshot(1, 1'b1, 63'({32{2'b10}}), 31'({16{2'b10}}), 1'b0);
      push_snapshot(1, 1'b1, 63'({32{2'b01}}), 31'({16{2'b01}}), 1'b0);
      push_snapshot(1, 1'b1, 63'({32{2'b10}}), 31'({16{2'b10}}), 1'b1);
      push_snapshot(7, 1'b1, 63'd5, 31'd5, 1'b0);
      push_snapshot(7, 1'b1, 63'd5, 31'd5, 1'b1);
      push_snapshot(2, 1'b0, TIME_MAX, COUNT_MAX, 1'b1);
      push_snapshot(3, 1'b1, 63'd1 << 62, 31'd1 << 30, 1'b1);
      wait_drained();

      // Updates disabled: statistics hold while frames still move on.
      write_enable(1'b0);
      push_snapshot(0, 1'b1, 63'd123, 31'd45, 1'b0);
      push_snapshot(1, 1'b1, TIME_MAX, COUNT_MAX, 1'b1);
      push_snapshot(15, 1'b0, '0, '0, 1'b1);
      push_snapshot(8, 1'b1, 63'd7, 31'd7, 1'b0);
      wait_drained();

      write_enable(1'b1);
      queue_frames(1250);
      wait_drained();

      write_enable(1'b0);
      queue_frames(150);
      wait_drained();

      write_enable(1'b1);
      @(posedge clock);
      calm = 1'b1;
      queue_frames(150);
      wait_drained();
      repeat (20) @(negedge clock);

      $display("Covered %0d snapshots and %0d results; %0d complete windows.",
               snapshots_taken, stats_seen, windows_closed);
      $display("%0d snapshots with updates disabled, %0d history slots overwritten.",
               skipped_updates, slots_reused);
      if (mismatches == 0 && stats_due_q.size() == 0) begin
         $display("windowed_profile_accumulator_unit: match");
      end else begin
         $display("windowed_profile_accumulator_unit: mismatch");
      end
      $finish;
   end

endmodule
